>>> hw/rtl/mcct_pkg.sv
// Package for the multi-channel countdown timer bank.
// Holds sizes, command and result codes, and the queue entry types.
// Depends on nothing; every other file of the block uses it.
package mcct_pkg;

  // Number of timer channels in the bank.
  localparam int unsigned CHANNELS = 8;

  // Index and counter widths that follow from the channel count.
  localparam int unsigned CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CNT_W    = $clog2(CHANNELS + 1);

  // Fixed field widths of the request and result channels.
  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned CHANNEL_W = 3;
  localparam int unsigned PERIOD_W  = 32;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned HANDLE_W  = 4;
  localparam int unsigned TICK_W    = 32;

  // Depth of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Command codes as they arrive on the request channel.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 3'd0,
    FUNC_SET   = 3'd1,
    FUNC_START = 3'd2,
    FUNC_STOP  = 3'd3,
    FUNC_RESET = 3'd4,
    FUNC_ALLOC = 3'd5
  } func_e;

  // Classified operations handed to the back end.
  typedef enum logic [2:0] {
    OP_TICK,
    OP_SET,
    OP_START,
    OP_STOP,
    OP_RESET,
    OP_ALLOC,
    OP_NOP
  } op_e;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_EXPIRED = 2'd0,
    KIND_HANDLE  = 2'd1,
    KIND_DONE    = 2'd2
  } kind_e;

  // Back end sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } back_state_e;

  // One classified command.
  typedef struct packed {
    op_e                 op;
    logic [CH_IDX_W-1:0] ch;
    logic [PERIOD_W-1:0] period;
    logic                one_shot;
  } cmd_t;

  // Head of the command queue as seen by the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmdq_t;

endpackage

>>> hw/rtl/mcct_stream_if.sv
// Valid/ready channel interfaces for requests and results of the timer bank.
// Depends on mcct_pkg for the field widths.

// Request channel: one command per request.
interface mcct_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [mcct_pkg::FUNC_W-1:0]    func;
  logic [mcct_pkg::CHANNEL_W-1:0] channel;
  logic [mcct_pkg::PERIOD_W-1:0]  period;
  logic                          one_shot;

  modport source (output valid, func, channel, period, one_shot, input ready);
  modport sink   (input valid, func, channel, period, one_shot, output ready);
endinterface

// Result channel: one event per non-tick request and one per tick expiry.
interface mcct_evt_if;
  logic                         valid;
  logic                         ready;
  logic [mcct_pkg::KIND_W-1:0]   event_kind;
  logic [mcct_pkg::CHANNEL_W-1:0] expired_channel;
  logic [mcct_pkg::HANDLE_W-1:0] handle;
  logic [mcct_pkg::TICK_W-1:0]   tick_count;
  logic                         last;

  modport source (output valid, event_kind, expired_channel, handle, tick_count, last,
                  input ready);
  modport sink   (input valid, event_kind, expired_channel, handle, tick_count, last,
                  output ready);
endinterface

>>> hw/rtl/mcct_front.sv
// Front end of the timer bank: accepts command requests, classifies them
// and holds them in a short queue. Depends on mcct_pkg and mcct_stream_if.
module mcct_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  mcct_cmd_if.sink        cmd_i,
  output mcct_pkg::cmdq_t q_o,
  input  logic            pop_i
);

  localparam int unsigned DEPTH = mcct_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CQ_W  = $clog2(DEPTH + 1);
  localparam int unsigned CHW   = mcct_pkg::CH_IDX_W;

  mcct_pkg::cmd_t   cls_cmd;
  mcct_pkg::cmd_t   mem_q [DEPTH];
  logic             ch_ok;
  logic             push;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CQ_W-1:0]  count_q, count_d;

  // Classify the request; commands on a missing channel become no-ops.
  always_comb begin
    ch_ok            = int'(cmd_i.channel) < int'(mcct_pkg::CHANNELS);
    cls_cmd.ch       = CHW'(cmd_i.channel);
    cls_cmd.period   = cmd_i.period;
    cls_cmd.one_shot = cmd_i.one_shot;
    case (mcct_pkg::func_e'(cmd_i.func))
      mcct_pkg::FUNC_TICK:  cls_cmd.op = mcct_pkg::OP_TICK;
      mcct_pkg::FUNC_SET:   cls_cmd.op = ch_ok ? mcct_pkg::OP_SET : mcct_pkg::OP_NOP;
      mcct_pkg::FUNC_START: cls_cmd.op = ch_ok ? mcct_pkg::OP_START : mcct_pkg::OP_NOP;
      mcct_pkg::FUNC_STOP:  cls_cmd.op = ch_ok ? mcct_pkg::OP_STOP : mcct_pkg::OP_NOP;
      mcct_pkg::FUNC_RESET: cls_cmd.op = ch_ok ? mcct_pkg::OP_RESET : mcct_pkg::OP_NOP;
      mcct_pkg::FUNC_ALLOC: cls_cmd.op = mcct_pkg::OP_ALLOC;
      default:              cls_cmd.op = mcct_pkg::OP_NOP;
    endcase
  end

  // Queue control: accept while there is room.
  assign cmd_i.ready = (count_q != CQ_W'(DEPTH));
  assign push        = cmd_i.valid && cmd_i.ready;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls_cmd;
    end
  end

  // Head of the queue.
  assign q_o.valid = (count_q != '0);
  assign q_o.cmd   = mem_q[rd_ptr_q];

`ifndef SYNTH
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CQ_W'(DEPTH))
    else $error("command queue count beyond its depth");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("command queue popped while empty");

  a_push_only_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop_i) |=> count_q == $past(count_q) + 1'b1)
    else $error("command queue count did not follow a push");
`endif

endmodule

>>> hw/rtl/mcct_back.sv
// Back end of the timer bank: executes queued commands on the channel state
// and serializes results and expiry events into an output register.
// Depends on mcct_pkg and mcct_stream_if.
module mcct_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mcct_pkg::cmdq_t q_i,
  output logic            pop_o,
  mcct_evt_if.source      evt_o
);

  localparam int unsigned N    = mcct_pkg::CHANNELS;
  localparam int unsigned CHW  = mcct_pkg::CH_IDX_W;
  localparam int unsigned CNTW = mcct_pkg::CNT_W;
  localparam int unsigned PW   = mcct_pkg::PERIOD_W;
  localparam int unsigned TW   = mcct_pkg::TICK_W;
  localparam int unsigned HW   = mcct_pkg::HANDLE_W;
  localparam int unsigned OCW  = mcct_pkg::CHANNEL_W;

  // Channel state.
  logic [N-1:0]  enabled_q, enabled_d;
  logic [N-1:0]  single_q, single_d;
  logic [PW-1:0] remaining_q [N];
  logic [PW-1:0] remaining_d [N];
  logic [PW-1:0] reload_q [N];
  logic [PW-1:0] reload_d [N];
  logic [CNTW-1:0] handles_q, handles_d;
  logic [TW-1:0]   ticks_q, ticks_d;

  // Sequencer.
  mcct_pkg::back_state_e state_q, state_d;
  logic [N-1:0]   mask_q, mask_d;
  logic [N-1:0]   active;
  logic [N-1:0]   expire;
  logic [N-1:0]   sel_oh;
  logic [CHW-1:0] sel_idx;
  logic           slot_free;
  logic           is_tick;
  logic           load;

  // Output register.
  logic            out_valid_q, out_valid_d;
  mcct_pkg::kind_e kind_q, kind_d;
  logic [OCW-1:0]  xch_q, xch_d;
  logic [HW-1:0]   handle_q, handle_d;
  logic [TW-1:0]   tcount_q, tcount_d;
  logic            last_q, last_d;

  assign slot_free = !out_valid_q || evt_o.ready;
  assign is_tick   = (q_i.cmd.op == mcct_pkg::OP_TICK);

  // Per-channel lanes: which channels count and which expire on a tick.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      active[i] = enabled_q[i] && (CNTW'(i) < handles_q);
      expire[i] = active[i] && (remaining_q[i] == PW'(1));
    end
  end

  // Lowest pending expiry.
  always_comb begin
    sel_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        sel_idx = CHW'(i);
      end
    end
    sel_oh = mask_q & (~mask_q + N'(1));
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mcct_pkg::ST_IDLE: begin
        if (q_i.valid && is_tick && (expire != '0)) begin
          state_d = mcct_pkg::ST_EMIT;
        end
      end
      mcct_pkg::ST_EMIT: begin
        if (slot_free && (mask_q == sel_oh)) begin
          state_d = mcct_pkg::ST_IDLE;
        end
      end
      default: state_d = mcct_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: queue pop, output load and pending mask.
  always_comb begin
    pop_o    = 1'b0;
    load     = 1'b0;
    mask_d   = mask_q;
    kind_d   = kind_q;
    xch_d    = xch_q;
    handle_d = handle_q;
    tcount_d = tcount_q;
    last_d   = last_q;
    case (state_q)
      mcct_pkg::ST_IDLE: begin
        if (q_i.valid && (is_tick || slot_free)) begin
          pop_o = 1'b1;
        end
        if (pop_o && is_tick) begin
          mask_d = expire;
        end
        if (pop_o && !is_tick) begin
          load     = 1'b1;
          xch_d    = '0;
          tcount_d = ticks_q;
          last_d   = 1'b1;
          if (q_i.cmd.op == mcct_pkg::OP_ALLOC) begin
            kind_d   = mcct_pkg::KIND_HANDLE;
            handle_d = HW'(handles_q);
          end else begin
            kind_d   = mcct_pkg::KIND_DONE;
            handle_d = '0;
          end
        end
      end
      mcct_pkg::ST_EMIT: begin
        if (slot_free) begin
          load     = 1'b1;
          mask_d   = mask_q & ~sel_oh;
          kind_d   = mcct_pkg::KIND_EXPIRED;
          xch_d    = OCW'(sel_idx);
          handle_d = '0;
          tcount_d = ticks_q;
          last_d   = (mask_q == sel_oh);
        end
      end
      default: ;
    endcase
    if (load) begin
      out_valid_d = 1'b1;
    end else if (evt_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Command execution on the channel state.
  always_comb begin
    enabled_d   = enabled_q;
    single_d    = single_q;
    remaining_d = remaining_q;
    reload_d    = reload_q;
    handles_d   = handles_q;
    ticks_d     = ticks_q;
    if (pop_o) begin
      case (q_i.cmd.op)
        mcct_pkg::OP_TICK: begin
          ticks_d = ticks_q + 1'b1;
          for (int i = 0; i < N; i++) begin
            if (expire[i]) begin
              remaining_d[i] = reload_q[i];
              if (single_q[i]) begin
                enabled_d[i] = 1'b0;
              end
            end else if (active[i]) begin
              remaining_d[i] = remaining_q[i] - 1'b1;
            end
          end
        end
        mcct_pkg::OP_SET: begin
          single_d[q_i.cmd.ch]    = q_i.cmd.one_shot;
          remaining_d[q_i.cmd.ch] = q_i.cmd.period;
          reload_d[q_i.cmd.ch]    = q_i.cmd.period;
        end
        mcct_pkg::OP_START: begin
          remaining_d[q_i.cmd.ch] = reload_q[q_i.cmd.ch];
          enabled_d[q_i.cmd.ch]   = 1'b1;
        end
        mcct_pkg::OP_STOP: begin
          enabled_d[q_i.cmd.ch] = 1'b0;
        end
        mcct_pkg::OP_RESET: begin
          enabled_d[q_i.cmd.ch]   = 1'b0;
          remaining_d[q_i.cmd.ch] = reload_q[q_i.cmd.ch];
        end
        mcct_pkg::OP_ALLOC: begin
          if (handles_q < CNTW'(N)) begin
            handles_d = handles_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Channel state and sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= '0;
      single_q    <= '0;
      handles_q   <= '0;
      ticks_q     <= '0;
      state_q     <= mcct_pkg::ST_IDLE;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < N; i++) begin
        remaining_q[i] <= '0;
        reload_q[i]    <= '0;
      end
    end else begin
      enabled_q   <= enabled_d;
      single_q    <= single_d;
      handles_q   <= handles_d;
      ticks_q     <= ticks_d;
      state_q     <= state_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
      remaining_q <= remaining_d;
      reload_q    <= reload_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    xch_q    <= xch_d;
    handle_q <= handle_d;
    tcount_q <= tcount_d;
    last_q   <= last_d;
  end

  assign evt_o.valid           = out_valid_q;
  assign evt_o.event_kind      = kind_q;
  assign evt_o.expired_channel = xch_q;
  assign evt_o.handle          = handle_q;
  assign evt_o.tick_count      = tcount_q;
  assign evt_o.last            = last_q;

`ifndef SYNTH
  a_emit_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mcct_pkg::ST_EMIT |-> mask_q != '0)
    else $error("emit state entered with no pending expiry");

  a_no_pop_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mcct_pkg::ST_EMIT |-> !pop_o)
    else $error("command taken while expiries are still pending");

  a_tick_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && q_i.cmd.op == mcct_pkg::OP_TICK) |=> ticks_q == $past(ticks_q) + 1'b1)
    else $error("tick count did not advance on a tick");

  a_handles_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    handles_q <= CNTW'(N))
    else $error("handle count beyond the channel count");
`endif

endmodule

>>> hw/rtl/multi_channel_countdown_timer.sv
// Multi-channel countdown timer bank, top level.
// Path: an accepted command waits in the command queue and its result is then
// registered in the output register; a tick's expiries go from the queue
// via the pending expiry mask into the single output register. No command is
// taken until all expiries are out; a non-tick one waits for a free register.
// Reset: asynchronous, active low; all channels, handles and ticks clear to 0.
module multi_channel_countdown_timer (
  input  logic       clk_i,
  input  logic       rst_ni,
  mcct_cmd_if.sink   cmd_i,
  mcct_evt_if.source evt_o
);

  mcct_pkg::cmdq_t q_head;
  logic            q_pop;

  // Request acceptance, classification and queueing.
  mcct_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_i),
    .q_o    (q_head),
    .pop_i  (q_pop)
  );

  // Command execution and event serialization.
  mcct_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_i    (q_head),
    .pop_o  (q_pop),
    .evt_o  (evt_o)
  );

endmodule

>>> bench/tb_multi_channel_countdown_timer.sv
// Self-checking bench for the multi-channel countdown timer bank.
// Drives command requests and checks every result against an in-bench timer bank model.
// Depends on mcct_pkg, the mcct_cmd_if/mcct_evt_if interfaces and the top level.
`timescale 1ns / 100ps

module tb_multi_channel_countdown_timer;

  // Command codes that the block does not define; they must still report done.
  localparam logic [mcct_pkg::FUNC_W-1:0] FUNC_SPARE6 = 3'd6;
  localparam logic [mcct_pkg::FUNC_W-1:0] FUNC_SPARE7 = 3'd7;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned SETTLE       = mcct_pkg::CHANNELS + 4;
  localparam int unsigned PHASE_ITEMS  = 40;
  localparam int unsigned SQUEEZE_ITEMS = 24;
  localparam int unsigned DIR_ROWS     = 26;

  // One command request as driven onto the request channel.
  typedef struct packed {
    logic [mcct_pkg::FUNC_W-1:0]    func;
    logic [mcct_pkg::CHANNEL_W-1:0] ch;
    logic [mcct_pkg::PERIOD_W-1:0]  period;
    logic                           shot;
  } cmd_req_t;

  // One result as seen on the result channel.
  typedef struct packed {
    mcct_pkg::kind_e                kind;
    logic [mcct_pkg::CHANNEL_W-1:0] ch;
    logic [mcct_pkg::HANDLE_W-1:0]  handle;
    logic [mcct_pkg::TICK_W-1:0]    ticks;
    logic                           last;
  } timer_evt_t;

  // Directed row: a request and, where obvious, its single result.
  typedef struct packed {
    cmd_req_t   req;
    logic       typed;
    timer_evt_t evt;
  } dir_row_t;

  localparam timer_evt_t NO_EVT = '{mcct_pkg::KIND_DONE, 3'd0, 4'd0, 32'd0, 1'b0};

  // Directed sequence: allocation, countdown from zero, one-shot and periodic
  // expiry, handle exhaustion, stop, reset and the unused command codes.
  dir_row_t directed_rows [DIR_ROWS] = '{
    '{'{mcct_pkg::FUNC_TICK,   3'd0, 32'd0,         1'b0}, 1'b0, NO_EVT},
    '{'{mcct_pkg::FUNC_ALLOC,  3'd0, 32'd0,         1'b0}, 1'b1,
      '{mcct_pkg::KIND_HANDLE, 3'd0, 4'd0, 32'd1, 1'b1}},
    '{'{mcct_pkg::FUNC_SET,    3'd0, 32'd1,         1'b0}, 1'b1,
      '{mcct_pkg::KIND_DONE, 3'd0, 4'd0, 32'd1, 1'b1}},
    '{'{mcct_pkg::FUNC_START,  3'd0, 32'd0,         1'b0}, 1'b1,
      '{mcct_pkg::KIND_DONE, 3'd0, 4'd0, 32'd1, 1'b1}},
    '{'{mcct_pkg::FUNC_TICK,   3'd0, 32'd0,         1'b0}, 1'b0, NO_EVT},
    '{'{mcct_pkg::FUNC_ALLOC,  3'd0, 32'd0,         1'b0}, 1'b1,
      '{mcct_pkg::KIND_HANDLE, 3'd0, 4'd1, 32'd2, 1'b1}},
    '{'{mcct_pkg::FUNC_SET,    3'd1, 32'd0,         1'b1}, 1'b1,
      '{mcct_pkg::KIND_DONE, 3'd0, 4'd0, 32'd2, 1'b1}},
    '{'{mcct_pkg::FUNC_START,  3'd1, 32'd0,         1'b0}, 1'b1,
      '{mcct_pkg::KIND_DONE, 3'd0, 4'd0, 32'd2, 1'b1}},
    '{'{mcct_pkg::FUNC_TICK,   3'd7, 32'hFFFF_FFFF, 1'b1}, 1'b0, NO_EVT},
    '{'{mcct_pkg::FUNC_SET,    3'd2, 32'hFFFF_FFFF, 1'b1}, 1'b1,
      '{mcct_pkg::KIND_DONE, 3'd0, 4'd0, 32'd3, 1'b1}},
    '{'{mcct_pkg::FUNC_START,  3'd2, 32'd0,         1'b0}, 1'b1,
      '{mcct_pkg::KIND_DONE, 3'd0, 4'd0, 32'd3, 1'b1}},
    '{'{mcct_pkg::FUNC_ALLOC,  3'd0, 32'd0,         1'b0}, 1'b1,
      '{mcct_pkg::KIND_HANDLE, 3'd0, 4'd2, 32'd3, 1'b1}},
    '{'{mcct_pkg::FUNC_ALLOC,  3'd0, 32'd0,         1'b0}, 1'b1,
      '{mcct_pkg::KIND_HANDLE, 3'd0, 4'd3, 32'd3, 1'b1}},
    '{'{mcct_pkg::FUNC_ALLOC,  3'd0, 32'd0,         1'b0}, 1'b1,
      '{mcct_pkg::KIND_HANDLE, 3'd0, 4'd4, 32'd3, 1'b1}},
    '{'{mcct_pkg::FUNC_ALLOC,  3'd0, 32'd0,         1'b0}, 1'b1,
      '{mcct_pkg::KIND_HANDLE, 3'd0, 4'd5, 32'd3, 1'b1}},
    '{'{mcct_pkg::FUNC_ALLOC,  3'd0, 32'd0,         1'b0}, 1'b1,
      '{mcct_pkg::KIND_HANDLE, 3'd0, 4'd6, 32'd3, 1'b1}},
    '{'{mcct_pkg::FUNC_ALLOC,  3'd0, 32'd0,         1'b0}, 1'b1,
      '{mcct_pkg::KIND_HANDLE, 3'd0, 4'd7, 32'd3, 1'b1}},
    '{'{mcct_pkg::FUNC_ALLOC,  3'd0, 32'd0,         1'b0}, 1'b1,
      '{mcct_pkg::KIND_HANDLE, 3'd0, 4'd8, 32'd3, 1'b1}},
    '{'{mcct_pkg::FUNC_SET,    3'd7, 32'd2,         1'b1}, 1'b1,
      '{mcct_pkg::KIND_DONE, 3'd0, 4'd0, 32'd3, 1'b1}},
    '{'{mcct_pkg::FUNC_START,  3'd7, 32'd0,         1'b0}, 1'b1,
      '{mcct_pkg::KIND_DONE, 3'd0, 4'd0, 32'd3, 1'b1}},
    '{'{mcct_pkg::FUNC_TICK,   3'd0, 32'd0,         1'b0}, 1'b0, NO_EVT},
    '{'{mcct_pkg::FUNC_TICK,   3'd0, 32'd0,         1'b0}, 1'b0, NO_EVT},
    '{'{mcct_pkg::FUNC_STOP,   3'd0, 32'd0,         1'b0}, 1'b1,
      '{mcct_pkg::KIND_DONE, 3'd0, 4'd0, 32'd5, 1'b1}},
    '{'{mcct_pkg::FUNC_RESET,  3'd1, 32'd0,         1'b0}, 1'b1,
      '{mcct_pkg::KIND_DONE, 3'd0, 4'd0, 32'd5, 1'b1}},
    '{'{FUNC_SPARE6,           3'd5, 32'h8000_0001, 1'b1}, 1'b1,
      '{mcct_pkg::KIND_DONE, 3'd0, 4'd0, 32'd5, 1'b1}},
    '{'{FUNC_SPARE7,           3'd6, 32'd7,         1'b0}, 1'b1,
      '{mcct_pkg::KIND_DONE, 3'd0, 4'd0, 32'd5, 1'b1}}
  };

  logic clk_i;
  logic rst_ni;

  mcct_cmd_if cmd_ch ();
  mcct_evt_if evt_ch ();

  multi_channel_countdown_timer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_ch),
    .evt_o  (evt_ch)
  );

  // Timer bank state as the bench expects it to be.
  logic                          chan_on      [mcct_pkg::CHANNELS] = '{default: 1'b0};
  logic [mcct_pkg::PERIOD_W-1:0] chan_left    [mcct_pkg::CHANNELS] = '{default: '0};
  logic [mcct_pkg::PERIOD_W-1:0] chan_reload  [mcct_pkg::CHANNELS] = '{default: '0};
  logic                          chan_oneshot [mcct_pkg::CHANNELS] = '{default: 1'b0};
  logic [mcct_pkg::CNT_W-1:0]    handles_taken = '0;
  logic [mcct_pkg::TICK_W-1:0]   tick_total    = '0;

  timer_evt_t  pending_events [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned snd_idle_pct   = 0;
  int unsigned rcv_stall_pct  = 0;
  int unsigned hold_reqs      = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Applies one command to the bench state and returns the results it causes.
  function automatic int timer_bank_step(input cmd_req_t r,
                                         output timer_evt_t evs [mcct_pkg::CHANNELS]);
    int n;
    n = 0;
    if (r.func == mcct_pkg::FUNC_TICK) begin
      tick_total = tick_total + 1'b1;
      // Walk the allocated channels in ascending order.
      for (int i = 0; i < mcct_pkg::CHANNELS && i < handles_taken; i++) begin
        if (chan_on[i]) begin
          chan_left[i] = chan_left[i] - 1'b1;
          if (chan_left[i] == '0) begin
            if (chan_oneshot[i]) chan_on[i] = 1'b0;
            chan_left[i] = chan_reload[i];
            evs[n] = '{mcct_pkg::KIND_EXPIRED, i[mcct_pkg::CHANNEL_W-1:0], '0,
                       tick_total, 1'b0};
            n++;
          end
        end
      end
      if (n > 0) evs[n-1].last = 1'b1;
    end else if (r.func == mcct_pkg::FUNC_ALLOC) begin
      evs[0] = '{mcct_pkg::KIND_HANDLE, '0, mcct_pkg::HANDLE_W'(handles_taken),
                 tick_total, 1'b1};
      if (handles_taken < mcct_pkg::CHANNELS) handles_taken = handles_taken + 1'b1;
      n = 1;
    end else begin
      if (r.ch < mcct_pkg::CHANNELS) begin
        case (r.func)
          mcct_pkg::FUNC_SET: begin
            chan_oneshot[r.ch] = r.shot;
            chan_left[r.ch]    = r.period;
            chan_reload[r.ch]  = r.period;
          end
          mcct_pkg::FUNC_START: begin
            chan_left[r.ch] = chan_reload[r.ch];
            chan_on[r.ch]   = 1'b1;
          end
          mcct_pkg::FUNC_STOP: begin
            chan_on[r.ch] = 1'b0;
          end
          mcct_pkg::FUNC_RESET: begin
            chan_on[r.ch]   = 1'b0;
            chan_left[r.ch] = chan_reload[r.ch];
          end
          default: ;
        endcase
      end
      evs[0] = '{mcct_pkg::KIND_DONE, '0, '0, tick_total, 1'b1};
      n = 1;
    end
    return n;
  endfunction

  // Random command, weighted toward ticks and short periods so channels expire often.
  function automatic cmd_req_t random_request();
    cmd_req_t r;
    int unsigned pick;
    pick     = $urandom_range(99);
    r.ch     = mcct_pkg::CHANNEL_W'($urandom_range(2**mcct_pkg::CHANNEL_W - 1));
    r.shot   = 1'($urandom_range(1));
    r.period = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(6);
    if (pick < 40)      r.func = mcct_pkg::FUNC_TICK;
    else if (pick < 55) r.func = mcct_pkg::FUNC_SET;
    else if (pick < 70) r.func = mcct_pkg::FUNC_START;
    else if (pick < 80) r.func = mcct_pkg::FUNC_STOP;
    else if (pick < 88) r.func = mcct_pkg::FUNC_RESET;
    else if (pick < 95) r.func = mcct_pkg::FUNC_ALLOC;
    else                r.func = $urandom_range(1) ? FUNC_SPARE6 : FUNC_SPARE7;
    return r;
  endfunction

  // Offers one request, waits for its acceptance and records what it should cause.
  // Valid stays high afterwards; it is lowered only before an idle gap.
  task automatic issue_request(input cmd_req_t r, input logic typed, input timer_evt_t typed_evt);
    timer_evt_t step_evts [mcct_pkg::CHANNELS];
    int produced;
    if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle_pct);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.func     <= r.func;
    cmd_ch.channel  <= r.ch;
    cmd_ch.period   <= r.period;
    cmd_ch.one_shot <= r.shot;
    do @(posedge clk_i); while (!cmd_ch.ready);
    produced = timer_bank_step(r, step_evts);
    if (typed) begin
      pending_events.push_back(typed_evt);
    end else begin
      for (int k = 0; k < produced; k++) pending_events.push_back(step_evts[k]);
    end
  endtask

  // Changes the idling mix away from the active edge, optionally with a long hold-off.
  task automatic set_idling(input int unsigned snd, input int unsigned rcv, input logic hold);
    @(negedge clk_i);
    snd_idle_pct  = snd;
    rcv_stall_pct = rcv;
    if (hold) hold_reqs++;
    @(posedge clk_i);
  endtask

  // Lowers valid and waits until every expected result has come out.
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic void flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // Result receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      evt_ch.ready <= 1'b0;
    end else begin
      evt_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    timer_evt_t want;
    if (evt_ch.valid && evt_ch.ready) begin
      if (pending_events.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: kind %0d ch %0d handle %0d ticks %0d last %0d",
                                evt_ch.event_kind, evt_ch.expired_channel, evt_ch.handle,
                                evt_ch.tick_count, evt_ch.last));
      end else begin
        want = pending_events.pop_front();
        if (want.kind !== evt_ch.event_kind || want.ch !== evt_ch.expired_channel ||
            want.handle !== evt_ch.handle || want.ticks !== evt_ch.tick_count ||
            want.last !== evt_ch.last) begin
          flag_mismatch($sformatf({"result mismatch: expected kind %0d ch %0d handle %0d",
                                   " ticks %0d last %0d, got kind %0d ch %0d handle %0d",
                                   " ticks %0d last %0d"},
                                  want.kind, want.ch, want.handle, want.ticks, want.last,
                                  evt_ch.event_kind, evt_ch.expired_channel, evt_ch.handle,
                                  evt_ch.tick_count, evt_ch.last));
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Stimulus: reset, directed rows, random phases, then a squeeze under a long hold-off.
  initial begin : stimulus
    int unsigned snd_mix [4];
    int unsigned rcv_mix [4];
    snd_mix = '{0, 51, 0, 35};
    rcv_mix = '{0, 0, 51, 35};
    rst_ni          = 1'b0;
    cmd_ch.valid    = 1'b0;
    cmd_ch.func     = mcct_pkg::FUNC_TICK;
    cmd_ch.channel  = '0;
    cmd_ch.period   = '0;
    cmd_ch.one_shot = 1'b0;
    evt_ch.ready    = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      issue_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].evt);
    end
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      set_idling(snd_mix[p], rcv_mix[p], 1'b0);
      repeat (PHASE_ITEMS) issue_request(random_request(), 1'b0, NO_EVT);
      wait_drained();
    end

    // Sender keeps offering while results are held back, so the block backs up.
    set_idling(0, 0, 1'b1);
    repeat (SQUEEZE_ITEMS) issue_request(random_request(), 1'b0, NO_EVT);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
